// ===== rtl/edge_clipped_box_blur_assert.svh =====
// Assertion macros for the box blur block
`ifndef EDGE_CLIPPED_BOX_BLUR_ASSERT_SVH
`define EDGE_CLIPPED_BOX_BLUR_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define ECBB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define ECBB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ecbb_pkg.sv =====
// ---------------------------------------------------------------------------
// ecbb_pkg
// Shared constants for the edge clipped box blur block.
// ---------------------------------------------------------------------------
package ecbb_pkg;
    localparam int DEF_RADIUS    = 10;
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int PIX_W         = 8;
    localparam int WCFG_W        = 11;
    localparam int HCFG_W        = 13;
    localparam int ROW_W         = 12;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

    localparam logic [WCFG_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [HCFG_W-1:0] HEIGHT_RST = 13'd480;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SUM  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;
endpackage

// ===== rtl/edge_clipped_box_blur.sv =====
// Flow: an emitting item walks its clipped window over the store (S_SUM), is divided by the
//   window size (S_DIV) and is handed to the output register (S_OUT).
// Stalls: an emitting item stalls the input until its result has entered the output
//   register, set by the window read loop on the single store read port; items that emit
//   nothing do not stall the input, and a register write stalls the input while it is made.
// Reset: synchronous active low; clears counters, handshake state and registers to 640x480.
// ---------------------------------------------------------------------------
// edge_clipped_box_blur
// Streaming box blur with a square window clipped at the frame edges.
// ---------------------------------------------------------------------------
module edge_clipped_box_blur #(
    parameter int RADIUS    = ecbb_pkg::DEF_RADIUS,
    parameter int MAX_WIDTH = ecbb_pkg::DEF_MAX_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ecbb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ecbb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_req_type,
    input  logic [ecbb_pkg::PIX_W-1:0]      i_pixel_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [ecbb_pkg::PIX_W-1:0]      o_blurred_pixel,
    output logic                            o_frame_last
);
    import ecbb_pkg::*;
    `include "edge_clipped_box_blur_assert.svh"

    localparam int DEPTH = 2 * RADIUS * MAX_WIDTH + 2 * RADIUS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RDW   = $clog2(2 * RADIUS + 2);
    localparam int CNTW  = $clog2((2 * RADIUS + 1) * (2 * RADIUS + 1) + 1);
    localparam int SUMW  = CNTW + PIX_W;
    localparam logic [RDW-1:0] RAD = RDW'(RADIUS);

    t_state r_state;
    logic [WCFG_W-1:0] r_wcfg;
    logic [HCFG_W-1:0] r_hcfg;
    logic [CW-1:0]     r_in_col, r_out_col;
    logic [ROW_W-1:0]  r_in_row, r_out_row;
    logic              r_done;
    logic [AW-1:0]     r_diff, r_wp, r_oaddr;
    logic [AW-1:0]     r_addr, r_rowstart;
    logic [RDW-1:0]    r_ncols, r_ccnt, r_rcnt;
    logic [CNTW-1:0]   r_count;
    logic [SUMW-1:0]   r_sum;
    logic              r_pend, r_iss_done, r_last;
    logic [PIX_W-1:0]  r_out_px;
    logic              r_out_last, r_out_valid;

    logic [WW-1:0]     w_eff;
    logic [HCFG_W-1:0] h_eff;
    logic [AW-1:0]     delay;
    logic              accept, pixel_go, emit, is_last;
    logic [RDW-1:0]    dr, dc, du, dl, nrows, ncols;
    logic [HCFG_W-1:0] down;
    logic [WW-1:0]     right;
    logic [AW-1:0]     back;
    logic [AW:0]       start_ext, next_row_ext;
    logic [PIX_W-1:0]  rdata;
    logic              div_start, div_done;
    logic [SUMW-1:0]   div_q;

    // clamp the frame geometry
    always_comb begin
        if (r_wcfg == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_wcfg) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_wcfg);
        end
        if (r_hcfg == '0) begin
            h_eff = HCFG_W'(1);
        end else if (32'(r_hcfg) > MAX_HEIGHT) begin
            h_eff = HCFG_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_hcfg;
        end
    end

    assign delay    = AW'(AW'(RADIUS) * AW'(w_eff)) + AW'(RADIUS);
    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign pixel_go = !r_done && (i_req_type == REQ_PIXEL);
    assign emit     = r_done || (pixel_go && (r_diff >= delay));
    assign is_last  = (HCFG_W'(r_out_row) == h_eff - 1'b1) && (WW'(r_out_col) == w_eff - 1'b1);

    // clipped window around the output position
    always_comb begin
        down  = h_eff - 1'b1 - HCFG_W'(r_out_row);
        right = w_eff - 1'b1 - WW'(r_out_col);
        dr    = (r_out_row < ROW_W'(RADIUS)) ? RDW'(r_out_row) : RAD;
        dc    = (32'(r_out_col) < RADIUS) ? RDW'(r_out_col) : RAD;
        du    = (down < HCFG_W'(RADIUS)) ? RDW'(down) : RAD;
        dl    = (32'(right) < RADIUS) ? RDW'(right) : RAD;
        nrows = dr + du + 1'b1;
        ncols = dc + dl + 1'b1;
        back  = AW'(AW'(dr) * AW'(w_eff)) + AW'(dc);
        if (r_oaddr >= back) begin
            start_ext = {1'b0, r_oaddr - back};
        end else begin
            start_ext = {1'b0, r_oaddr} + (AW + 1)'(DEPTH) - {1'b0, back};
        end
        next_row_ext = {1'b0, r_rowstart} + (AW + 1)'(w_eff);
        if (next_row_ext >= (AW + 1)'(DEPTH)) begin
            next_row_ext = next_row_ext - (AW + 1)'(DEPTH);
        end
    end

    // frame position, store pointers and sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wcfg     <= WIDTH_RST;
            r_hcfg     <= HEIGHT_RST;
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_done     <= 1'b0;
            r_diff     <= '0;
            r_wp       <= '0;
            r_oaddr    <= '0;
            r_pend     <= 1'b0;
            r_iss_done <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_we) begin
                        if (i_cfg_index == REG_WIDTH) begin
                            r_wcfg <= i_cfg_data[WCFG_W-1:0];
                        end
                        if (i_cfg_index == REG_WIDTH || i_cfg_index == REG_HEIGHT) begin
                            r_in_col  <= '0;
                            r_in_row  <= '0;
                            r_out_col <= '0;
                            r_out_row <= '0;
                            r_done    <= 1'b0;
                            r_diff    <= '0;
                            r_wp      <= '0;
                            r_oaddr   <= '0;
                        end
                        if (i_cfg_index == REG_HEIGHT) begin
                            r_hcfg <= i_cfg_data;
                        end
                    end else if (accept) begin
                        if (pixel_go) begin
                            r_wp <= (32'(r_wp) == DEPTH - 1) ? '0 : r_wp + 1'b1;
                            if (!emit) begin
                                r_diff <= r_diff + 1'b1;
                            end
                            if (WW'(r_in_col) + 1'b1 == w_eff) begin
                                r_in_col <= '0;
                                if (HCFG_W'(r_in_row) + 1'b1 == h_eff) begin
                                    r_in_row <= '0;
                                    r_done   <= 1'b1;
                                end else begin
                                    r_in_row <= r_in_row + 1'b1;
                                end
                            end else begin
                                r_in_col <= r_in_col + 1'b1;
                            end
                        end
                        if (emit) begin
                            r_state    <= S_SUM;
                            r_iss_done <= 1'b0;
                            r_pend     <= 1'b0;
                            if (is_last) begin
                                r_in_col  <= '0;
                                r_in_row  <= '0;
                                r_out_col <= '0;
                                r_out_row <= '0;
                                r_done    <= 1'b0;
                                r_diff    <= '0;
                                r_wp      <= '0;
                                r_oaddr   <= '0;
                            end else begin
                                r_oaddr <= (32'(r_oaddr) == DEPTH - 1) ? '0 : r_oaddr + 1'b1;
                                if (WW'(r_out_col) + 1'b1 == w_eff) begin
                                    r_out_col <= '0;
                                    r_out_row <= r_out_row + 1'b1;
                                end else begin
                                    r_out_col <= r_out_col + 1'b1;
                                end
                            end
                        end
                    end
                end
                S_SUM: begin
                    r_pend <= !r_iss_done;
                    if (!r_iss_done && r_ccnt == RDW'(1) && r_rcnt == RDW'(1)) begin
                        r_iss_done <= 1'b1;
                    end
                    if (r_iss_done && !r_pend) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // window walk and accumulation
    always_ff @(posedge i_clk) begin
        if (accept && emit && !i_cfg_we) begin
            r_addr     <= start_ext[AW-1:0];
            r_rowstart <= start_ext[AW-1:0];
            r_ncols    <= ncols;
            r_ccnt     <= ncols;
            r_rcnt     <= nrows;
            r_count    <= CNTW'(CNTW'(nrows) * CNTW'(ncols));
            r_sum      <= '0;
            r_last     <= is_last;
        end else if (r_state == S_SUM) begin
            if (r_pend) begin
                r_sum <= r_sum + SUMW'(rdata);
            end
            if (!r_iss_done) begin
                if (r_ccnt == RDW'(1)) begin
                    r_ccnt     <= r_ncols;
                    r_rcnt     <= r_rcnt - 1'b1;
                    r_rowstart <= next_row_ext[AW-1:0];
                    r_addr     <= next_row_ext[AW-1:0];
                end else begin
                    r_ccnt <= r_ccnt - 1'b1;
                    r_addr <= (32'(r_addr) == DEPTH - 1) ? '0 : r_addr + 1'b1;
                end
            end
        end
    end

    assign div_start = (r_state == S_SUM) && r_iss_done && !r_pend;

    ecbb_line_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (accept && pixel_go && !i_cfg_we),
        .i_waddr (r_wp),
        .i_wdata (i_pixel_in),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    ecbb_divider #(
        .SUMW (SUMW),
        .CNTW (CNTW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && (!r_out_valid || !i_out_stall)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_out_valid || !i_out_stall)) begin
            r_out_px   <= div_q[PIX_W-1:0];
            r_out_last <= r_last;
        end
    end

    // hold the input while busy or while a register is written
    assign o_in_stall      = (r_state != S_IDLE) || i_cfg_we;
    assign o_out_valid     = r_out_valid;
    assign o_blurred_pixel = r_out_px;
    assign o_frame_last    = r_out_last;

    // checks
    `ECBB_ASSERT_NOW(a_reads_drained, i_clk, i_rst_n, r_state == S_DIV, !r_pend,
        "divider running with a store read outstanding")
    `ECBB_ASSERT_NOW(a_mean_fits, i_clk, i_rst_n, r_state == S_OUT,
        div_q[SUMW-1:PIX_W] == '0, "window mean exceeds pixel range")
    `ECBB_ASSERT_NOW(a_lead_bound, i_clk, i_rst_n, !r_done, r_diff <= delay,
        "input lead beyond window delay")
    `ECBB_ASSERT_NEXT(a_sum_start, i_clk, i_rst_n, accept && emit && !i_cfg_we,
        r_state == S_SUM, "emitting item did not start the window walk")
endmodule

// ===== rtl/ecbb_line_store.sv =====
// ---------------------------------------------------------------------------
// ecbb_line_store
// Circular pixel store: one write port, one registered read port.
// ---------------------------------------------------------------------------
module ecbb_line_store #(
    parameter int DEPTH = 20501,
    parameter int AW    = 15
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [ecbb_pkg::PIX_W-1:0] i_wdata,
    input  logic [AW-1:0]              i_raddr,
    output logic [ecbb_pkg::PIX_W-1:0] o_rdata
);
    import ecbb_pkg::*;

    logic [PIX_W-1:0] r_mem [DEPTH];

    // write the incoming pixel
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/ecbb_divider.sv =====
// ---------------------------------------------------------------------------
// ecbb_divider
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ecbb_divider #(
    parameter int SUMW = 17,
    parameter int CNTW = 9
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [SUMW-1:0] i_dividend,
    input  logic [CNTW-1:0] i_divisor,
    output logic            o_done,
    output logic [SUMW-1:0] o_quotient
);
    import ecbb_pkg::*;

    localparam int STW = $clog2(SUMW + 1);

    logic [SUMW-1:0] r_quo;
    logic [CNTW-1:0] r_rem;
    logic [CNTW-1:0] r_div;
    logic [STW-1:0]  r_cnt;
    logic            r_done;
    logic [CNTW:0]   rem_sh;
    logic            fits;

    assign rem_sh = {r_rem, r_quo[SUMW-1]};
    assign fits   = rem_sh >= {1'b0, r_div};

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= STW'(SUMW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift and subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            if (fits) begin
                r_rem <= CNTW'(rem_sh - {1'b0, r_div});
            end else begin
                r_rem <= rem_sh[CNTW-1:0];
            end
            r_quo <= {r_quo[SUMW-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule
